/* design/ray_box_intersect_macros.svh */
// ----------------------------------------------------------------------------
// ray_box_intersect_macros
// assertion macros shared by the ray box checker
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_INTERSECT_MACROS_SVH
`define RAY_BOX_INTERSECT_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define RBI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbi checker: property failed");

// next-cycle implication on aclk, off during reset
`define RBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbi checker: property failed");

`endif

/* design/rbi_pkg.sv */
// ----------------------------------------------------------------------------
// rbi_pkg
// types and constants of the ray box intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int HW_BITS       = 30;
    localparam int NUM_AXES      = 3;
    localparam int DIFF_BITS     = COORD_BITS + 2;
    localparam int NUM_BITS      = DIFF_BITS - 1 + FRAC_BITS;
    localparam int QUO_BITS      = COORD_BITS - 1;
    localparam int QIDX_BITS     = $clog2(QUO_BITS);
    localparam int DIV_STEP      = 2;
    localparam int DIV_STAGES    = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int WIDE_BITS     = 2 * COORD_BITS;
    localparam int PT_BITS       = WIDE_BITS - FRAC_BITS + 2;
    localparam int CFG_ADDR_BITS = 8;

    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTRE_X   = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTRE_Y   = CFG_ADDR_BITS'(1);
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTRE_Z   = CFG_ADDR_BITS'(2);
    localparam logic [CFG_ADDR_BITS-1:0] REG_HALF_WIDTH = CFG_ADDR_BITS'(3);

    localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(1) << FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  bound_t;
    typedef logic [NUM_BITS-1:0]          num_t;
    typedef logic [COORD_BITS-1:0]        den_t;
    typedef logic [QUO_BITS-1:0]          quo_t;
    typedef logic [WIDE_BITS-1:0]         prod_t;
    typedef logic signed [PT_BITS-1:0]    pt_t;

    localparam pt_t SAT_HI = {{(PT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam pt_t SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic                     in_box;
        logic [NUM_AXES-1:0]      outside;
        logic [NUM_AXES-1:0]      ok;
        logic [NUM_AXES-1:0]      ovf;
        coord_t [NUM_AXES-1:0]    org;
        coord_t [NUM_AXES-1:0]    dir;
        bound_t [NUM_AXES-1:0]    cand;
        num_t [NUM_AXES-1:0]      rem;
        den_t [NUM_AXES-1:0]      den;
        quo_t [NUM_AXES-1:0]      quo;
        quo_t                     tsel;
        logic [1:0]               axis;
        logic                     miss;
        prod_t [NUM_AXES-1:0]     prod;
        pt_t [NUM_AXES-1:0]       pt;
    } ray_t;

    typedef struct packed {
        logic                     hit;
        logic                     origin_inside;
        logic [1:0]               axis;
        coord_t [NUM_AXES-1:0]    pos;
    } result_t;

endpackage

`default_nettype wire

/* design/ray_box_intersect.sv */
// throughput: one ray per cycle; a result stall squeezes bubbles out, holds the stages past them
// the t division runs as a 16-stage restoring divider, 2 quotient bits per stage, 1 in the last
// reset: pipeline empty, box centre at the origin, half width 1.0
// ----------------------------------------------------------------------------
// ray_box_intersect
// pipelined fixed point ray against axis-aligned cube test
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_intersect (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rbi_pkg::coord_t                    s_origin_x,
    input  rbi_pkg::coord_t                    s_origin_y,
    input  rbi_pkg::coord_t                    s_origin_z,
    input  rbi_pkg::coord_t                    s_dir_x,
    input  rbi_pkg::coord_t                    s_dir_y,
    input  rbi_pkg::coord_t                    s_dir_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic                               m_origin_inside,
    output logic [1:0]                         m_hit_axis,
    output rbi_pkg::coord_t                    m_hit_x,
    output rbi_pkg::coord_t                    m_hit_y,
    output rbi_pkg::coord_t                    m_hit_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbi_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  rbi_pkg::coord_t                    cfg_wdata
);
    import rbi_pkg::*;

    localparam int ST_CLASS   = 0;
    localparam int ST_DIFF    = 1;
    localparam int ST_OVF     = 2;
    localparam int ST_DIV0    = 3;
    localparam int ST_SEL     = ST_DIV0 + DIV_STAGES;
    localparam int ST_MUL     = ST_SEL + 1;
    localparam int ST_ADD     = ST_MUL + 1;
    localparam int NUM_STAGES = ST_ADD + 1;

    coord_t [NUM_AXES-1:0]  centre_reg;
    logic [HW_BITS-1:0]     hw_reg;
    bound_t [NUM_AXES-1:0]  lo_bound;
    bound_t [NUM_AXES-1:0]  hi_bound;

    ray_t                   pipe_reg  [NUM_STAGES];
    ray_t                   pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]  vld_reg;
    logic [NUM_STAGES:0]    adv;

    result_t                res_reg;
    result_t                res_next;
    logic                   m_valid_reg;

    coord_t [NUM_AXES-1:0]  in_org;
    coord_t [NUM_AXES-1:0]  in_dir;

    function automatic bound_t ext_coord(coord_t v);
        return {{(DIFF_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic pt_t ext_bound(bound_t v);
        return {{(PT_BITS-DIFF_BITS){v[DIFF_BITS-1]}}, v};
    endfunction

    function automatic coord_t sat_coord(pt_t v);
        pt_t r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return r[COORD_BITS-1:0];
    endfunction

    // per axis slab classification and candidate plane
    function automatic ray_t classify(coord_t [NUM_AXES-1:0] org, coord_t [NUM_AXES-1:0] dir,
                                      bound_t [NUM_AXES-1:0] lo, bound_t [NUM_AXES-1:0] hi);
        ray_t   n;
        bound_t o;
        n        = '0;
        n.in_box = 1'b1;
        n.org    = org;
        n.dir    = dir;
        for (int i = 0; i < NUM_AXES; i++) begin
            o = ext_coord(org[i]);
            if ($signed(o) < $signed(lo[i])) begin
                n.cand[i]    = lo[i];
                n.outside[i] = 1'b1;
                n.in_box     = 1'b0;
            end else if ($signed(o) > $signed(hi[i])) begin
                n.cand[i]    = hi[i];
                n.outside[i] = 1'b1;
                n.in_box     = 1'b0;
            end
        end
        return n;
    endfunction

    // distance to plane, magnitudes for the divider
    function automatic ray_t diff_stage(ray_t p);
        ray_t   n;
        bound_t d;
        bound_t a;
        n = p;
        for (int i = 0; i < NUM_AXES; i++) begin
            d        = $signed(p.cand[i]) - $signed(ext_coord(p.org[i]));
            a        = d[DIFF_BITS-1] ? -d : d;
            n.rem[i] = {a[DIFF_BITS-2:0], {FRAC_BITS{1'b0}}};
            n.den[i] = p.dir[i][COORD_BITS-1] ? -p.dir[i] : p.dir[i];
            n.ok[i]  = p.outside[i] && (p.dir[i] != '0)
                       && (d[DIFF_BITS-1] == p.dir[i][COORD_BITS-1]);
        end
        return n;
    endfunction

    function automatic ray_t ovf_stage(ray_t p);
        ray_t n;
        n = p;
        for (int i = 0; i < NUM_AXES; i++) begin
            n.ovf[i] = {{(WIDE_BITS-NUM_BITS){1'b0}}, p.rem[i]}
                       >= ({{(WIDE_BITS-COORD_BITS){1'b0}}, p.den[i]} << QUO_BITS);
            n.quo[i] = '0;
        end
        return n;
    endfunction

    // restoring division, up to DIV_STEP quotient bits per stage
    function automatic ray_t div_stage(ray_t p, int j);
        ray_t                 n;
        logic [WIDE_BITS-1:0] sh;
        int                   k;
        n = p;
        for (int i = 0; i < NUM_AXES; i++) begin
            for (int b = 0; b < DIV_STEP; b++) begin
                k = QUO_BITS - 1 - j * DIV_STEP - b;
                if (k >= 0) begin
                    sh = {{(WIDE_BITS-COORD_BITS){1'b0}}, n.den[i]} << k;
                    if ({{(WIDE_BITS-NUM_BITS){1'b0}}, n.rem[i]} >= sh) begin
                        n.rem[i]                    = n.rem[i] - sh[NUM_BITS-1:0];
                        n.quo[i][k[QIDX_BITS-1:0]] = 1'b1;
                    end
                end
            end
        end
        return n;
    endfunction

    // largest t wins, ties to the lowest axis; negative t marks no entry
    function automatic ray_t sel_stage(ray_t p);
        ray_t                  n;
        coord_t [NUM_AXES-1:0] t;
        logic [1:0]            ax;
        n = p;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (!p.ok[i]) begin
                t[i] = '1;
            end else if (p.ovf[i]) begin
                t[i] = {1'b0, {QUO_BITS{1'b1}}};
            end else begin
                t[i] = {1'b0, p.quo[i]};
            end
        end
        ax = 2'd0;
        if ($signed(t[0]) < $signed(t[1])) begin
            ax = 2'd1;
        end
        if ($signed(t[ax]) < $signed(t[2])) begin
            ax = 2'd2;
        end
        n.axis = ax;
        n.tsel = t[ax][QUO_BITS-1:0];
        n.miss = t[ax][COORD_BITS-1];
        return n;
    endfunction

    function automatic ray_t mul_stage(ray_t p);
        ray_t                        n;
        logic signed [COORD_BITS-1:0] ts;
        logic signed [WIDE_BITS-1:0]  pr;
        n  = p;
        ts = $signed({1'b0, p.tsel});
        for (int i = 0; i < NUM_AXES; i++) begin
            pr        = ts * $signed(p.dir[i]);
            n.prod[i] = pr;
        end
        return n;
    endfunction

    function automatic ray_t add_stage(ray_t p);
        ray_t n;
        n = p;
        for (int i = 0; i < NUM_AXES; i++) begin
            n.pt[i] = $signed({{(PT_BITS-COORD_BITS){p.org[i][COORD_BITS-1]}}, p.org[i]})
                    + $signed({{(PT_BITS-WIDE_BITS+FRAC_BITS){p.prod[i][WIDE_BITS-1]}},
                               p.prod[i][WIDE_BITS-1:FRAC_BITS]});
        end
        return n;
    endfunction

    function automatic result_t finish(ray_t p, bound_t [NUM_AXES-1:0] lo,
                                       bound_t [NUM_AXES-1:0] hi);
        result_t r;
        pt_t     v;
        logic    bad;
        r   = '0;
        bad = 1'b0;
        if (p.in_box) begin
            r.hit           = 1'b1;
            r.origin_inside = 1'b1;
            r.pos           = p.org;
        end else if (!p.miss) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (p.axis == 2'(i)) begin
                    v = ext_bound(p.cand[i]);
                end else begin
                    v = p.pt[i];
                    if (v < ext_bound(lo[i]) || v > ext_bound(hi[i])) begin
                        bad = 1'b1;
                    end
                end
                r.pos[i] = sat_coord(v);
            end
            if (bad) begin
                r = '0;
            end else begin
                r.hit  = 1'b1;
                r.axis = p.axis;
            end
        end
        return r;
    endfunction

    assign in_org = {s_origin_z, s_origin_y, s_origin_x};
    assign in_dir = {s_dir_z, s_dir_y, s_dir_x};

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            lo_bound[i] = $signed(ext_coord(centre_reg[i]))
                        - $signed({{(DIFF_BITS-HW_BITS){1'b0}}, hw_reg});
            hi_bound[i] = $signed(ext_coord(centre_reg[i]))
                        + $signed({{(DIFF_BITS-HW_BITS){1'b0}}, hw_reg});
        end
    end

    always_comb begin
        pipe_next[ST_CLASS] = classify(in_org, in_dir, lo_bound, hi_bound);
        pipe_next[ST_DIFF]  = diff_stage(pipe_reg[ST_CLASS]);
        pipe_next[ST_OVF]   = ovf_stage(pipe_reg[ST_DIFF]);
        for (int j = 0; j < DIV_STAGES; j++) begin
            pipe_next[ST_DIV0+j] = div_stage(pipe_reg[ST_DIV0+j-1], j);
        end
        pipe_next[ST_SEL]   = sel_stage(pipe_reg[ST_SEL-1]);
        pipe_next[ST_MUL]   = mul_stage(pipe_reg[ST_SEL]);
        pipe_next[ST_ADD]   = add_stage(pipe_reg[ST_MUL]);
        res_next            = finish(pipe_reg[ST_ADD], lo_bound, hi_bound);
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        adv[NUM_STAGES] = !m_valid_reg || m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (adv[NUM_STAGES]) begin
                m_valid_reg <= vld_reg[NUM_STAGES-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (adv[NUM_STAGES]) begin
            res_reg <= res_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg <= '0;
            hw_reg     <= HW_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_CENTRE_X:   centre_reg[0] <= cfg_wdata;
                REG_CENTRE_Y:   centre_reg[1] <= cfg_wdata;
                REG_CENTRE_Z:   centre_reg[2] <= cfg_wdata;
                REG_HALF_WIDTH: hw_reg        <= cfg_wdata[HW_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready       = aresetn;
    assign s_ready         = aresetn && adv[0];
    assign m_valid         = m_valid_reg;
    assign m_hit           = res_reg.hit;
    assign m_origin_inside = res_reg.origin_inside;
    assign m_hit_axis      = res_reg.axis;
    assign m_hit_x         = res_reg.pos[0];
    assign m_hit_y         = res_reg.pos[1];
    assign m_hit_z         = res_reg.pos[2];

endmodule

`default_nettype wire

/* design/rbi_checker.sv */
// ----------------------------------------------------------------------------
// rbi_checker
// port level checks on the ray box result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_box_intersect_macros.svh"

module rbi_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input logic            m_hit,
    input logic            m_origin_inside,
    input logic [1:0]      m_hit_axis,
    input rbi_pkg::coord_t m_hit_x,
    input rbi_pkg::coord_t m_hit_y,
    input rbi_pkg::coord_t m_hit_z
);
    import rbi_pkg::*;

    // a miss carries an all-zero payload
    `RBI_ASSERT_NOW(a_miss_zero, m_valid && !m_hit, !m_origin_inside && m_hit_axis == 2'd0 && m_hit_x == '0 && m_hit_y == '0 && m_hit_z == '0)

    // origin inside is always a hit on axis zero
    `RBI_ASSERT_NOW(a_inside_hit, m_valid && m_origin_inside, m_hit && m_hit_axis == 2'd0)

    // a stalled result stays put
    `RBI_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_hit_x) && $stable(m_hit_axis))

endmodule

bind ray_box_intersect rbi_checker u_rbi_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams rays through the box test and compares each transaction against a
// behavioral predictor of the slab test; the box is reconfigured between phases
// ----------------------------------------------------------------------------

module testbench;

    import rbi_pkg::*;

    typedef struct {
        coord_t org [3];
        coord_t dir [3];
    } ray_item_t;

    typedef struct {
        logic       hit;
        logic       in_box;
        logic [1:0] axis;
        coord_t     pos [3];
    } hit_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    coord_t s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit, m_origin_inside;
    logic [1:0] m_hit_axis;
    coord_t m_hit_x, m_hit_y, m_hit_z;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    coord_t cfg_wdata = '0;

    ray_item_t ray_queue [$];
    hit_item_t hit_queue [$];
    int  errors = 0;
    int  sent = 0;
    bit  hold_rx = 1'b0;
    bit  idle_enable = 1'b1;

    longint box_c [3];
    longint box_hw;

    always #5 aclk = ~aclk;

    ray_box_intersect u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_origin_inside(m_origin_inside), .m_hit_axis(m_hit_axis),
        .m_hit_x(m_hit_x), .m_hit_y(m_hit_y), .m_hit_z(m_hit_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic hit_item_t slab_test(ray_item_t r);
        hit_item_t res;
        longint o [3], d [3], lo [3], hi [3], cand [3], t [3], pt [3];
        bit     outside [3];
        bit     all_in;
        bit     missed;
        int     ax;
        longint one;
        one = 64'sd65536;
        all_in = 1'b1;
        missed = 1'b0;
        res.hit = 1'b0;
        res.in_box = 1'b0;
        res.axis = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res.pos[i] = '0;
            o[i] = r.org[i];
            d[i] = r.dir[i];
            lo[i] = box_c[i] - box_hw;
            hi[i] = box_c[i] + box_hw;
            cand[i] = 0;
            outside[i] = 1'b1;
            if (o[i] < lo[i]) begin
                cand[i] = lo[i];
                all_in = 1'b0;
            end else if (o[i] > hi[i]) begin
                cand[i] = hi[i];
                all_in = 1'b0;
            end else begin
                outside[i] = 1'b0;
            end
        end
        if (all_in) begin
            res.hit = 1'b1;
            res.in_box = 1'b1;
            for (int i = 0; i < 3; i++)
                res.pos[i] = r.org[i];
            return res;
        end
        for (int i = 0; i < 3; i++)
            t[i] = (outside[i] && d[i] != 0) ?
                clamp_coord(div_floor((cand[i] - o[i]) * one, d[i])) : -one;
        ax = 0;
        for (int i = 1; i < 3; i++)
            if (t[ax] < t[i])
                ax = i;
        if (t[ax] < 0)
            return res;
        for (int i = 0; i < 3; i++) begin
            if (i == ax) begin
                pt[i] = cand[i];
            end else begin
                pt[i] = o[i] + div_floor(t[ax] * d[i], one);
                if (pt[i] < lo[i] || pt[i] > hi[i])
                    missed = 1'b1;
            end
        end
        if (missed)
            return res;
        res.hit = 1'b1;
        res.axis = 2'(ax);
        for (int i = 0; i < 3; i++)
            res.pos[i] = coord_t'(clamp_coord(pt[i]));
        return res;
    endfunction

    // driver
    int gap_tx = 0;
    always @(posedge aclk) begin
        int draw_tx;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                hit_queue.push_back(slab_test(ray_queue.pop_front()));
                sent <= sent + 1;
                draw_tx = idle_enable ? $urandom_range(0, 6) : 0;
                gap_tx <= (draw_tx > 0) ? draw_tx - 1 : 0;
                if (draw_tx == 0 && ray_queue.size() > 0) begin
                    s_origin_x <= ray_queue[0].org[0];
                    s_origin_y <= ray_queue[0].org[1];
                    s_origin_z <= ray_queue[0].org[2];
                    s_dir_x <= ray_queue[0].dir[0];
                    s_dir_y <= ray_queue[0].dir[1];
                    s_dir_z <= ray_queue[0].dir[2];
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (gap_tx > 0) begin
                    gap_tx <= gap_tx - 1;
                end else if (ray_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_origin_x <= ray_queue[0].org[0];
                    s_origin_y <= ray_queue[0].org[1];
                    s_origin_z <= ray_queue[0].org[2];
                    s_dir_x <= ray_queue[0].dir[0];
                    s_dir_y <= ray_queue[0].dir[1];
                    s_dir_z <= ray_queue[0].dir[2];
                end
            end
        end
    end

    // monitor
    int gap_rx = 0;
    always @(posedge aclk) begin
        hit_item_t exp_hit;
        int        draw_rx;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t unexpected result transaction", $time);
                    errors++;
                end else begin
                    exp_hit = hit_queue.pop_front();
                    if (m_hit !== exp_hit.hit) begin
                        $display("%0t hit exp %0b got %0b", $time, exp_hit.hit, m_hit);
                        errors++;
                    end
                    if (m_origin_inside !== exp_hit.in_box) begin
                        $display("%0t origin_inside exp %0b got %0b", $time,
                                 exp_hit.in_box, m_origin_inside);
                        errors++;
                    end
                    if (m_hit_axis !== exp_hit.axis) begin
                        $display("%0t hit_axis exp %0d got %0d", $time,
                                 exp_hit.axis, m_hit_axis);
                        errors++;
                    end
                    if (m_hit_x !== exp_hit.pos[0]) begin
                        $display("%0t hit_x exp %0d got %0d", $time, exp_hit.pos[0], m_hit_x);
                        errors++;
                    end
                    if (m_hit_y !== exp_hit.pos[1]) begin
                        $display("%0t hit_y exp %0d got %0d", $time, exp_hit.pos[1], m_hit_y);
                        errors++;
                    end
                    if (m_hit_z !== exp_hit.pos[2]) begin
                        $display("%0t hit_z exp %0d got %0d", $time, exp_hit.pos[2], m_hit_z);
                        errors++;
                    end
                end
            end
            if (hold_rx) begin
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                draw_rx = idle_enable ? $urandom_range(0, 6) : 0;
                gap_rx <= (draw_rx > 0) ? draw_rx - 1 : 0;
                m_ready <= (draw_rx == 0);
            end else if (gap_rx > 0) begin
                gap_rx <= gap_rx - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_ray(coord_t ox, coord_t oy, coord_t oz,
                           coord_t dx, coord_t dy, coord_t dz);
        ray_item_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        ray_queue.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, coord_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CENTRE_X: box_c[0] = longint'(val);
            REG_CENTRE_Y: box_c[1] = longint'(val);
            REG_CENTRE_Z: box_c[2] = longint'(val);
            REG_HALF_WIDTH: box_hw = longint'(val[HW_BITS-1:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (ray_queue.size() > 0 || s_valid || hit_queue.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic coord_t rand_coord(longint span);
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom);
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return 0;
            default: return coord_t'(longint'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // rays aimed at the box mostly, with random content
    task automatic add_random(int n);
        coord_t o [3], d [3], tgt [3];
        longint span;
        for (int k = 0; k < n; k++) begin
            span = (box_hw > 0 ? box_hw : 64'sd65536) * 4;
            if (span > 64'sd1000000000)
                span = 64'sd1000000000;
            for (int i = 0; i < 3; i++) begin
                o[i] = coord_t'(clamp_coord(box_c[i] + rand_coord(span)));
                tgt[i] = coord_t'(clamp_coord(box_c[i] +
                         longint'($urandom_range(0, 2 * 65536)) - 65536));
                if ($urandom_range(0, 3) == 0)
                    d[i] = rand_coord(span);
                else
                    d[i] = coord_t'((longint'(tgt[i]) - longint'(o[i])) >>> $urandom_range(0, 4));
                if ($urandom_range(0, 7) == 0)
                    d[i] = 0;
            end
            if ($urandom_range(0, 9) == 0)
                o[$urandom_range(0, 2)] = coord_t'(box_c[0]);
            add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        end
    endtask

    initial begin
        box_c[0] = 0; box_c[1] = 0; box_c[2] = 0;
        box_hw = 64'sd65536;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rays against the reset box
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(32'sh10000, -32'sh10000, 32'sh10000, 0, 0, 0);
        add_ray(-32'sh30000, 0, 0, 32'sh10000, 0, 0);
        add_ray(32'sh30000, 0, 0, -32'sh10000, 0, 0);
        add_ray(0, -32'sh30000, 0, 0, 32'sh10000, 0);
        add_ray(0, 0, 32'sh30000, 0, 0, -32'sh10000);
        add_ray(-32'sh30000, 0, 0, -32'sh10000, 0, 0);
        add_ray(-32'sh30000, 0, 0, 0, 0, 0);
        add_ray(-32'sh30000, -32'sh30000, 0, 32'sh10000, 32'sh10000, 0);
        add_ray(-32'sh30000, -32'sh50000, 0, 32'sh10000, 32'sh10000, 0);
        add_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_ray(32'sh80000000, 0, 0, 1, 0, 0);
        add_ray(32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
        add_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 1, -1);
        add_ray(-32'sh10001, 32'sh20000, 0, 32'sh10000, -32'sh10000, 0);
        add_ray(-32'sh30000, 32'sh50000, 0, 32'sh10000, -32'sh10000, 1);
        add_ray(32'sh10000, 32'sh10000, 32'sh10001, 5, 7, -3);
        add_random(200);
        drain();

        write_reg(REG_CENTRE_X, 32'sh7fffffff);
        write_reg(REG_CENTRE_Y, 32'sh80000000);
        write_reg(REG_CENTRE_Z, 32'sh00123456);
        write_reg(REG_HALF_WIDTH, 32'sh3fffffff);
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(32'sh80000000, 32'sh7fffffff, 0, 1, -1, 0);
        add_random(300);

        // long receiver hold so the pipeline backs up
        fork
            begin
                hold_rx = 1'b1;
                repeat (200) @(posedge aclk);
                hold_rx = 1'b0;
            end
        join_none
        drain();

        write_reg(REG_HALF_WIDTH, 0);
        write_reg(REG_CENTRE_X, 32'sh00050000);
        write_reg(8'd7, 32'sh12345678);
        add_ray(32'sh00050000, 0, 0, 0, 0, 0);
        add_random(300);
        drain();

        write_reg(REG_CENTRE_X, -32'sh00020000);
        write_reg(REG_CENTRE_Y, 32'sh00010000);
        write_reg(REG_CENTRE_Z, 0);
        write_reg(REG_HALF_WIDTH, 32'sh00008000);
        idle_enable = 1'b0;
        add_random(300);
        drain();
        idle_enable = 1'b1;

        write_reg(REG_HALF_WIDTH, 32'sh00100000);
        add_random(400);
        drain();

        if (errors == 0)
            $display("[ray_box_intersect] OK");
        else
            $display("[ray_box_intersect] ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("[ray_box_intersect] ERROR");
        $finish;
    end

endmodule
